// ----- rtl/ptz_timed_move_commander_core_assert.svh -----
`ifndef PTZ_TIMED_MOVE_COMMANDER_CORE_ASSERT_SVH
`define PTZ_TIMED_MOVE_COMMANDER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PTZC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ptzc: property violated");

// A stalled beat keeps its valid and its payload until it is taken.
`define PTZC_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
    else $error("ptzc: stalled beat changed");

`endif

// ----- rtl/ptzc_pkg.sv -----
`default_nettype none

package ptzc_pkg;

  localparam int KIND_W  = 2;
  localparam int DIR_W   = 3;
  localparam int SPEED_W = 4;
  localparam int ANGLE_W = 10;
  localparam int BYTE_W  = 8;
  localparam int MS_W    = 20;
  localparam int PADDR_W = 3;

  localparam logic [KIND_W-1:0] KIND_MOVE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  localparam logic [DIR_W-1:0] DIR_TILT_A    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_TILT_B    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_PAN_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_PAN_RIGHT = 3'd4;

  localparam logic [SPEED_W-1:0] TILT_LIMIT = 4'd5;
  localparam logic [SPEED_W-1:0] PAN_LIMIT  = 4'd9;
  localparam logic [9:0]         MS_PER_S   = 10'd1000;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] CMD_STOP  = 8'h00;

  localparam logic [2:0] FRAME_LAST_IDX = 3'd6;

  localparam logic REG_IDX_DEVICE_ADDRESS = 1'b0;
  localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RESET = 8'd1;

  function automatic logic [BYTE_W-1:0] dir_cmd(input logic [DIR_W-1:0] dir);
    logic [BYTE_W-1:0] cmd;
    case (dir)
      DIR_TILT_A:    cmd = 8'h10;
      DIR_TILT_B:    cmd = 8'h08;
      DIR_PAN_LEFT:  cmd = 8'h04;
      DIR_PAN_RIGHT: cmd = 8'h02;
      default:       cmd = CMD_STOP;
    endcase
    return cmd;
  endfunction

  // Speed byte floor(speed * 53 / limit) for every legal speed.
  function automatic logic [BYTE_W-1:0] speed_byte(input logic is_pan,
                                                   input logic [SPEED_W-1:0] speed);
    logic [BYTE_W-1:0] sb;
    sb = 8'd0;
    if (is_pan) begin
      case (speed)
        4'd1:    sb = 8'd5;
        4'd2:    sb = 8'd11;
        4'd3:    sb = 8'd17;
        4'd4:    sb = 8'd23;
        4'd5:    sb = 8'd29;
        4'd6:    sb = 8'd35;
        4'd7:    sb = 8'd41;
        4'd8:    sb = 8'd47;
        4'd9:    sb = 8'd53;
        default: sb = 8'd0;
      endcase
    end else begin
      case (speed)
        4'd1:    sb = 8'd10;
        4'd2:    sb = 8'd21;
        4'd3:    sb = 8'd31;
        4'd4:    sb = 8'd42;
        4'd5:    sb = 8'd53;
        default: sb = 8'd0;
      endcase
    end
    return sb;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ptzc_if.sv -----
`default_nettype none

interface ptzc_in_if
  import ptzc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [DIR_W-1:0]   direction;
  logic [SPEED_W-1:0] speed;
  logic [ANGLE_W-1:0] angle;

  modport source (output valid, kind, direction, speed, angle, input ready);
  modport sink (input valid, kind, direction, speed, angle, output ready);
endinterface

interface ptzc_out_if
  import ptzc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              status;
  logic              frame_type;
  logic              last;

  modport source (output valid, frame_byte, status, frame_type, last, input ready);
  modport sink (input valid, frame_byte, status, frame_type, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/ptz_timed_move_commander_core.sv -----
// Channel   Role    Handshake               Beat contents
// in_i      sink    valid/ready             kind, direction, speed, angle
// out_o     source  valid/ready             frame_byte, status, frame_type, last
// APB       slave   psel/penable, pready=1  device_address at byte address 0
//
// A move is accepted, runs the shared bit-serial divider, then sends 7 output
// beats, or one reject beat for a bad speed; a stop takes 7 beats; a tick steps
// four countdowns via the shared subtractor, then sends 7 beats per expired one.
// Reset clears all countdowns and sets the device address to 1.
// The output register holds a stalled beat; in_i.ready is high only when idle.
`default_nettype none

module ptz_timed_move_commander_core
  import ptzc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  ptzc_in_if.sink            in_i,
  ptzc_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_TICK,
    S_FRAME,
    S_REJ
  } state_e;

  state_e             state_q;
  logic [BYTE_W-1:0]  addr_q;
  logic [MS_W-1:0]    rem_q [4];
  logic [3:0]         act_q;
  logic [1:0]         slot_q;
  logic [4:0]         step_q;
  logic [3:0]         mask_q;
  logic [MS_W-1:0]    quo_q;
  logic [SPEED_W-1:0] part_q;
  logic [SPEED_W-1:0] speed_q;
  logic [BYTE_W-1:0]  cmd_q;
  logic [BYTE_W-1:0]  pan_q;
  logic [BYTE_W-1:0]  tilt_q;
  logic               ftype_q;
  logic [2:0]         idx_q;
  logic [BYTE_W-1:0]  sum_q;

  logic               ov_q;
  logic [BYTE_W-1:0]  obyte_q;
  logic               ostat_q;
  logic               oftype_q;
  logic               olast_q;

  logic               in_fire;
  logic               out_free;
  logic               dir_ok;
  logic               is_pan;
  logic [SPEED_W-1:0] limit;
  logic               speed_ok;
  logic [3:0]         expire;
  logic [SPEED_W:0]   trial;
  logic [MS_W:0]      sub_a;
  logic [MS_W:0]      sub_b;
  logic [MS_W:0]      sub_diff;
  logic               borrow;
  logic [MS_W-1:0]    quo_next;
  logic [BYTE_W-1:0]  cur_byte;
  logic [3:0]         mask_next;

  assign in_i.ready       = (state_q == S_IDLE);
  assign in_fire          = in_i.valid && in_i.ready;
  assign out_free         = !ov_q || out_o.ready;
  assign out_o.valid      = ov_q;
  assign out_o.frame_byte = obyte_q;
  assign out_o.status     = ostat_q;
  assign out_o.frame_type = oftype_q;
  assign out_o.last       = olast_q;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_IDX_DEVICE_ADDRESS) ? {24'd0, addr_q} : 32'd0;

  always_comb begin
    dir_ok   = in_i.direction inside {[DIR_TILT_A:DIR_PAN_RIGHT]};
    is_pan   = in_i.direction inside {DIR_PAN_LEFT, DIR_PAN_RIGHT};
    limit    = is_pan ? PAN_LIMIT : TILT_LIMIT;
    speed_ok = (in_i.speed != '0) && (in_i.speed <= limit);
    for (int i = 0; i < 4; i++) begin
      expire[i] = act_q[i] && (rem_q[i][MS_W-1:1] == '0);
    end
  end

  always_comb begin
    trial = {part_q, quo_q[MS_W-1]};
    if (state_q == S_DIV) begin
      sub_a = {{(MS_W-SPEED_W){1'b0}}, trial};
      sub_b = {{(MS_W+1-SPEED_W){1'b0}}, speed_q};
    end else begin
      sub_a = {1'b0, rem_q[slot_q]};
      sub_b = {{MS_W{1'b0}}, 1'b1};
    end
    sub_diff = sub_a - sub_b;
    borrow   = sub_diff[MS_W];
    quo_next = {quo_q[MS_W-2:0], !borrow};
  end

  always_comb begin
    case (idx_q)
      3'd0:    cur_byte = SYNC_BYTE;
      3'd1:    cur_byte = addr_q;
      3'd2:    cur_byte = 8'h00;
      3'd3:    cur_byte = cmd_q;
      3'd4:    cur_byte = pan_q;
      3'd5:    cur_byte = tilt_q;
      default: cur_byte = sum_q;
    endcase
    mask_next = mask_q & (mask_q - 4'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      addr_q  <= DEVICE_ADDRESS_RESET;
      rem_q   <= '{default: '0};
      act_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready
          && (paddr[PADDR_W-1] == REG_IDX_DEVICE_ADDRESS)) begin
        addr_q <= pwdata[BYTE_W-1:0];
      end

      if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            idx_q  <= '0;
            mask_q <= 4'b0001;
            case (in_i.kind)
              KIND_MOVE: begin
                if (dir_ok) begin
                  if (speed_ok) begin
                    quo_q   <= MS_W'(in_i.angle) * MS_W'(MS_PER_S);
                    part_q  <= '0;
                    step_q  <= '0;
                    speed_q <= in_i.speed;
                    slot_q  <= 2'(in_i.direction - DIR_TILT_A);
                    cmd_q   <= dir_cmd(in_i.direction);
                    pan_q   <= is_pan ? speed_byte(is_pan, in_i.speed) : 8'h00;
                    tilt_q  <= is_pan ? 8'h00 : speed_byte(is_pan, in_i.speed);
                    ftype_q <= 1'b0;
                    state_q <= S_DIV;
                  end else begin
                    state_q <= S_REJ;
                  end
                end
              end
              KIND_STOP: begin
                cmd_q   <= CMD_STOP;
                pan_q   <= 8'h00;
                tilt_q  <= 8'h00;
                ftype_q <= 1'b1;
                state_q <= S_FRAME;
              end
              KIND_TICK: begin
                cmd_q   <= CMD_STOP;
                pan_q   <= 8'h00;
                tilt_q  <= 8'h00;
                ftype_q <= 1'b1;
                mask_q  <= expire;
                slot_q  <= '0;
                state_q <= S_TICK;
              end
              default: begin
              end
            endcase
          end
        end

        S_DIV: begin
          quo_q  <= quo_next;
          part_q <= borrow ? trial[SPEED_W-1:0] : sub_diff[SPEED_W-1:0];
          step_q <= step_q + 5'd1;
          if (step_q == 5'(MS_W - 1)) begin
            rem_q[slot_q] <= quo_next;
            act_q[slot_q] <= 1'b1;
            state_q       <= S_FRAME;
          end
        end

        S_TICK: begin
          if (act_q[slot_q]) begin
            if (mask_q[slot_q]) begin
              rem_q[slot_q] <= '0;
              act_q[slot_q] <= 1'b0;
            end else begin
              rem_q[slot_q] <= sub_diff[MS_W-1:0];
            end
          end
          slot_q <= slot_q + 2'd1;
          if (slot_q == 2'd3) begin
            state_q <= (mask_q != '0) ? S_FRAME : S_IDLE;
          end
        end

        S_FRAME: begin
          if (out_free) begin
            ov_q     <= 1'b1;
            obyte_q  <= cur_byte;
            ostat_q  <= 1'b0;
            oftype_q <= ftype_q;
            olast_q  <= (idx_q == FRAME_LAST_IDX) && (mask_next == '0);
            sum_q    <= (idx_q == 3'd0) ? 8'h00 : sum_q + cur_byte;
            if (idx_q == FRAME_LAST_IDX) begin
              idx_q  <= '0;
              mask_q <= mask_next;
              if (mask_next == '0) begin
                state_q <= S_IDLE;
              end
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end

        S_REJ: begin
          if (out_free) begin
            ov_q     <= 1'b1;
            obyte_q  <= 8'h00;
            ostat_q  <= 1'b1;
            oftype_q <= 1'b0;
            olast_q  <= 1'b1;
            state_q  <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ptzc_checker.sv -----
`default_nettype none

`include "ptz_timed_move_commander_core_assert.svh"

module ptzc_checker
  import ptzc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BYTE_W-1:0] frame_byte_i,
  input logic              status_i,
  input logic              frame_type_i,
  input logic              last_i
);

  // A waiting beat that is not the last of its item means more beats are due.
  `PTZC_ASSERT(a_busy_mid_frame, clk_i, rst_ni, (out_valid_i && !last_i) |-> !in_ready_i)

  // A reject is a single zero beat that closes its item.
  `PTZC_ASSERT(a_reject_shape, clk_i, rst_ni, (out_valid_i && status_i) |-> (last_i && (frame_byte_i == 8'h00) && !frame_type_i))

  // A frame beat that comes right after a finished item is the sync byte.
  `PTZC_ASSERT(a_sync_after_last, clk_i, rst_ni, (out_valid_i && out_ready_i && last_i && !status_i) |=> (!out_valid_i || status_i || (frame_byte_i == SYNC_BYTE)))

  `PTZC_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, ({frame_byte_i, status_i, frame_type_i, last_i}))

endmodule

bind ptz_timed_move_commander_core ptzc_checker u_ptzc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .frame_byte_i (out_o.frame_byte),
  .status_i     (out_o.status),
  .frame_type_i (out_o.frame_type),
  .last_i       (out_o.last)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
  import ptzc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic [BYTE_W-1:0] CMD_TILT_A    = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_TILT_B    = 8'h08;
  localparam logic [BYTE_W-1:0] CMD_PAN_LEFT  = 8'h04;
  localparam logic [BYTE_W-1:0] CMD_PAN_RIGHT = 8'h02;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;
  localparam logic FTYPE_MOVE    = 1'b0;
  localparam logic FTYPE_STOP    = 1'b1;

  localparam int SPEED_SCALE     = 53;
  localparam int SETTLE_CYCLES   = 40;
  localparam int STALL_LIMIT     = 5000;
  localparam int RANDOM_PHASES   = 4;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int LONG_RUN_TICKS  = 112;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DIR_W-1:0]   direction;
    logic [SPEED_W-1:0] speed;
    logic [ANGLE_W-1:0] angle;
  } ptz_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              status;
    logic              frame_type;
    logic              last;
  } ptz_beat_t;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  ptzc_in_if  cmd_bus();
  ptzc_out_if beat_bus();

  ptz_timed_move_commander_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_bus),
    .out_o   (beat_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted state of the commander.
  logic [MS_W-1:0]   ms_left [4];
  logic              timer_on [4];
  logic [BYTE_W-1:0] cam_addr = DEVICE_ADDRESS_RESET;

  ptz_cmd_t    pending_cmds [$];
  ptz_beat_t   due_beats [$];
  int unsigned cmds_queued  = 0;
  int unsigned cmds_taken   = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cmd_wait;
  int unsigned beat_wait;
  bit          steady = 1'b0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int unsigned idle_draw();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("mismatch in %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
  endtask

  function automatic void push_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] pan,
                                     input logic [BYTE_W-1:0] tilt, input logic ftype);
    logic [BYTE_W-1:0] frame [7];
    ptz_beat_t         beat;
    frame[0] = SYNC_BYTE;
    frame[1] = cam_addr;
    frame[2] = 8'h00;
    frame[3] = cmd;
    frame[4] = pan;
    frame[5] = tilt;
    frame[6] = cam_addr + cmd + pan + tilt;
    for (int k = 0; k < 7; k++) begin
      beat.frame_byte = frame[k];
      beat.status     = STATUS_OK;
      beat.frame_type = ftype;
      beat.last       = 1'b0;
      due_beats.push_back(beat);
    end
  endfunction

  function automatic void predict_frames(input ptz_cmd_t c);
    int unsigned       slot;
    int unsigned       limit;
    int unsigned       first;
    logic              is_pan;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] sb;
    ptz_beat_t         beat;
    first = due_beats.size();
    case (c.kind)
      KIND_MOVE: begin
        if (c.direction >= DIR_TILT_A && c.direction <= DIR_PAN_RIGHT) begin
          slot   = c.direction - DIR_TILT_A;
          is_pan = (c.direction >= DIR_PAN_LEFT);
          limit  = is_pan ? PAN_LIMIT : TILT_LIMIT;
          if (c.speed == 0 || c.speed > limit) begin
            beat.frame_byte = 8'h00;
            beat.status     = STATUS_REJECT;
            beat.frame_type = FTYPE_MOVE;
            beat.last       = 1'b1;
            due_beats.push_back(beat);
          end else begin
            case (c.direction)
              DIR_TILT_A:   cmd = CMD_TILT_A;
              DIR_TILT_B:   cmd = CMD_TILT_B;
              DIR_PAN_LEFT: cmd = CMD_PAN_LEFT;
              default:      cmd = CMD_PAN_RIGHT;
            endcase
            sb = BYTE_W'((int'(c.speed) * SPEED_SCALE) / limit);
            if (is_pan) begin
              push_frame(cmd, sb, 8'h00, FTYPE_MOVE);
            end else begin
              push_frame(cmd, 8'h00, sb, FTYPE_MOVE);
            end
            ms_left[slot]  = MS_W'((int'(c.angle) * int'(MS_PER_S)) / int'(c.speed));
            timer_on[slot] = 1'b1;
          end
        end
      end
      KIND_STOP: begin
        push_frame(CMD_STOP, 8'h00, 8'h00, FTYPE_STOP);
      end
      KIND_TICK: begin
        for (int s = 0; s < 4; s++) begin
          if (timer_on[s]) begin
            if (ms_left[s] <= 1) begin
              ms_left[s]  = '0;
              timer_on[s] = 1'b0;
              push_frame(CMD_STOP, 8'h00, 8'h00, FTYPE_STOP);
            end else begin
              ms_left[s] = ms_left[s] - 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (due_beats.size() > first) begin
      due_beats[due_beats.size() - 1].last = 1'b1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ptz_cmd_t nxt;
    if (!rst_ni) begin
      cmd_bus.valid     <= 1'b0;
      cmd_bus.kind      <= '0;
      cmd_bus.direction <= '0;
      cmd_bus.speed     <= '0;
      cmd_bus.angle     <= '0;
      cmd_wait          <= 0;
    end else if (!cmd_bus.valid || cmd_bus.ready) begin
      if (cmd_wait != 0) begin
        cmd_bus.valid <= 1'b0;
        cmd_wait      <= cmd_wait - 1;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        cmd_bus.valid     <= 1'b1;
        cmd_bus.kind      <= nxt.kind;
        cmd_bus.direction <= nxt.direction;
        cmd_bus.speed     <= nxt.speed;
        cmd_bus.angle     <= nxt.angle;
        cmd_wait          <= idle_draw();
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned d;
    if (!rst_ni) begin
      beat_bus.ready <= 1'b0;
      beat_wait      <= 0;
    end else if (beat_bus.valid && beat_bus.ready) begin
      d = idle_draw();
      beat_wait      <= d;
      beat_bus.ready <= (d == 0);
    end else if (beat_wait != 0) begin
      beat_wait      <= beat_wait - 1;
      beat_bus.ready <= (beat_wait == 1);
    end else begin
      beat_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    ptz_cmd_t  seen;
    ptz_beat_t want;
    if (!rst_ni) begin
      for (int s = 0; s < 4; s++) begin
        ms_left[s]  = '0;
        timer_on[s] = 1'b0;
      end
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        seen.kind      = cmd_bus.kind;
        seen.direction = cmd_bus.direction;
        seen.speed     = cmd_bus.speed;
        seen.angle     = cmd_bus.angle;
        predict_frames(seen);
        cmds_taken++;
      end
      if (beat_bus.valid && beat_bus.ready) begin
        if (due_beats.size() == 0) begin
          report_mismatch("unexpected beat", beat_bus.frame_byte, 0);
        end else begin
          want = due_beats.pop_front();
          if (beat_bus.frame_byte !== want.frame_byte) begin
            report_mismatch("frame_byte", beat_bus.frame_byte, want.frame_byte);
          end
          if (beat_bus.status !== want.status) begin
            report_mismatch("status", beat_bus.status, want.status);
          end
          if (beat_bus.frame_type !== want.frame_type) begin
            report_mismatch("frame_type", beat_bus.frame_type, want.frame_type);
          end
          if (beat_bus.last !== want.last) begin
            report_mismatch("last", beat_bus.last, want.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (beat_bus.valid && beat_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_cmd(input logic [KIND_W-1:0] kind,
                                    input logic [DIR_W-1:0] direction,
                                    input logic [SPEED_W-1:0] speed,
                                    input logic [ANGLE_W-1:0] angle);
    ptz_cmd_t c;
    c.kind      = kind;
    c.direction = direction;
    c.speed     = speed;
    c.angle     = angle;
    pending_cmds.push_back(c);
    cmds_queued++;
  endfunction

  function automatic ptz_cmd_t random_cmd();
    ptz_cmd_t    c;
    int unsigned roll;
    c.direction = DIR_W'($urandom);
    c.speed     = SPEED_W'($urandom);
    c.angle     = ANGLE_W'($urandom_range(0, 1023));
    roll        = $urandom_range(0, 99);
    if (roll < 45) begin
      c.kind = KIND_MOVE;
      if ($urandom_range(0, 9) != 0) begin
        c.direction = DIR_W'($urandom_range(DIR_TILT_A, DIR_PAN_RIGHT));
      end
      if ($urandom_range(0, 4) != 0) begin
        c.speed = SPEED_W'($urandom_range(1, (c.direction >= DIR_PAN_LEFT) ?
                                              PAN_LIMIT : TILT_LIMIT));
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: c.angle = '0;
        5, 6, 7:       c.angle = ANGLE_W'($urandom_range(1, 3));
        default: begin
        end
      endcase
    end else if (roll < 60) begin
      c.kind = KIND_STOP;
    end else if (roll < 95) begin
      c.kind = KIND_TICK;
    end else begin
      c.kind = KIND_SPARE;
    end
    return c;
  endfunction

  task automatic settle();
    while (cmds_taken != cmds_queued || due_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_address();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'(4 * int'(REG_IDX_DEVICE_ADDRESS));
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {24'd0, cam_addr}) begin
      report_mismatch("device_address readback", prdata, cam_addr);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_address(input logic [BYTE_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(REG_IDX_DEVICE_ADDRESS));
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cam_addr = value;
    check_address();
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned useful;
    ptz_cmd_t    c;
    useful = 0;
    while (useful < target) begin
      if (useful % 20 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      c = random_cmd();
      pending_cmds.push_back(c);
      cmds_queued++;
      if (c.kind != KIND_SPARE && !(c.kind == KIND_MOVE &&
          (c.direction < DIR_TILT_A || c.direction > DIR_PAN_RIGHT))) begin
        useful++;
      end
      while (pending_cmds.size() > 3) begin
        @(posedge clk_i);
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] addr_val;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_address();

    // Arm all four countdowns at both speed limits and let three expire together.
    queue_cmd(KIND_MOVE, DIR_TILT_A, 4'd5, 10'd0);
    queue_cmd(KIND_MOVE, DIR_TILT_B, 4'd1, 10'd1023);
    queue_cmd(KIND_MOVE, DIR_PAN_LEFT, 4'd9, 10'd0);
    queue_cmd(KIND_MOVE, DIR_PAN_RIGHT, 4'd1, 10'd0);
    queue_cmd(KIND_TICK, 3'd0, 4'd0, 10'd0);
    // A new move replaces the long countdown still running on its slot.
    queue_cmd(KIND_MOVE, DIR_TILT_B, 4'd3, 10'd0);
    queue_cmd(KIND_MOVE, DIR_TILT_A, 4'd1, 10'd0);
    queue_cmd(KIND_MOVE, DIR_PAN_LEFT, 4'd4, 10'd0);
    queue_cmd(KIND_MOVE, DIR_PAN_RIGHT, 4'd8, 10'd0);
    queue_cmd(KIND_TICK, 3'd7, 4'd15, 10'd1023);
    queue_cmd(KIND_MOVE, DIR_TILT_A, 4'd0, 10'd5);
    queue_cmd(KIND_MOVE, DIR_TILT_B, 4'd6, 10'd5);
    queue_cmd(KIND_MOVE, DIR_PAN_LEFT, 4'd10, 10'd5);
    queue_cmd(KIND_MOVE, DIR_PAN_RIGHT, 4'd15, 10'd1023);
    queue_cmd(KIND_MOVE, DIR_PAN_LEFT, 4'd0, 10'd0);
    queue_cmd(KIND_MOVE, 3'd0, 4'd3, 10'd0);
    queue_cmd(KIND_MOVE, 3'd5, 4'd3, 10'd0);
    queue_cmd(KIND_MOVE, 3'd7, 4'd15, 10'd1023);
    queue_cmd(KIND_STOP, 3'd0, 4'd0, 10'd0);
    queue_cmd(KIND_SPARE, 3'd7, 4'd15, 10'd1023);
    queue_cmd(KIND_MOVE, DIR_PAN_RIGHT, 4'd9, 10'd1);
    queue_cmd(KIND_TICK, 3'd0, 4'd0, 10'd0);
    queue_cmd(KIND_STOP, 3'd7, 4'd15, 10'd1023);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       addr_val = 8'h00;
        1:       addr_val = 8'hFF;
        default: addr_val = BYTE_W'($urandom_range(0, 255));
      endcase
      set_address(addr_val);
      if (p == 1) begin
        // Run one countdown all the way down through the value of one.
        queue_cmd(KIND_MOVE, DIR_PAN_LEFT, 4'd9, 10'd1);
        for (int t = 0; t < LONG_RUN_TICKS; t++) begin
          queue_cmd(KIND_TICK, DIR_W'($urandom), SPEED_W'($urandom), ANGLE_W'($urandom));
          while (pending_cmds.size() > 3) begin
            @(posedge clk_i);
          end
        end
      end
      random_phase(ITEMS_PER_PHASE);
      settle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
